@@ src/ufpe_pkg.sv @@
// Shared types, constants and register codes for the UART frame pulse encoder.
package ufpe_pkg;

   localparam int DATA_BITS  = 8;
   localparam int SENT_BITS  = (DATA_BITS > 8) ? 8 : DATA_BITS;
   localparam int SYMBOLS    = SENT_BITS + 2;
   localparam int IDX_W      = $clog2(SYMBOLS);
   localparam int BIT_SEL_W  = 3;
   localparam int TICK_W     = 15;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = TICK_W;

   localparam logic [IDX_W-1:0] IDX_START = '0;
   localparam logic [IDX_W-1:0] IDX_STOP  = IDX_W'(SYMBOLS - 1);

   typedef enum logic [1:0] {
      PARITY_NONE = 2'd0,
      PARITY_EVEN = 2'd1,
      PARITY_ODD  = 2'd2
   } parity_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PARITY_MODE     = 3'd0,
      CSR_HALF_BIT_TICKS  = 3'd1,
      CSR_FULL_BIT_TICKS  = 3'd2,
      CSR_STOP_HALF_TICKS = 3'd3,
      CSR_STOP_FULL_TICKS = 3'd4
   } csr_index_type;

   typedef struct packed {
      parity_mode_type    parity_mode;
      logic [TICK_W-1:0]  half_bit_ticks;
      logic [TICK_W-1:0]  full_bit_ticks;
      logic [TICK_W-1:0]  stop_half_ticks;
      logic [TICK_W-1:0]  stop_full_ticks;
   } cfg_type;

   typedef struct packed {
      logic               first_level;
      logic [TICK_W-1:0]  first_ticks;
      logic               second_level;
      logic [TICK_W-1:0]  second_ticks;
      logic               last_symbol;
   } sym_type;

endpackage

@@ src/ufpe_csr.sv @@
// Configuration registers of the UART frame pulse encoder.
module ufpe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ufpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ufpe_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output ufpe_pkg::cfg_type                  cfg
);

   ufpe_pkg::cfg_type cfg_ff;
   ufpe_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (ufpe_pkg::csr_index_type'(csr_index))
            ufpe_pkg::CSR_PARITY_MODE:
               cfg_in.parity_mode = ufpe_pkg::parity_mode_type'(csr_wdata[1:0]);
            ufpe_pkg::CSR_HALF_BIT_TICKS:  cfg_in.half_bit_ticks  = csr_wdata;
            ufpe_pkg::CSR_FULL_BIT_TICKS:  cfg_in.full_bit_ticks  = csr_wdata;
            ufpe_pkg::CSR_STOP_HALF_TICKS: cfg_in.stop_half_ticks = csr_wdata;
            ufpe_pkg::CSR_STOP_FULL_TICKS: cfg_in.stop_full_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.parity_mode     <= ufpe_pkg::PARITY_NONE;
         cfg_ff.half_bit_ticks  <= ufpe_pkg::TICK_W'(1);
         cfg_ff.full_bit_ticks  <= ufpe_pkg::TICK_W'(1);
         cfg_ff.stop_half_ticks <= ufpe_pkg::TICK_W'(1);
         cfg_ff.stop_full_ticks <= ufpe_pkg::TICK_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/ufpe_sym.sv @@
// Symbol builder: level and tick count of each half for one frame position.
module ufpe_sym (
   input  ufpe_pkg::cfg_type                  cfg,
   input  logic [ufpe_pkg::BYTE_W-1:0]        data_byte,
   input  logic [ufpe_pkg::IDX_W-1:0]         idx,
   output ufpe_pkg::sym_type                  sym
);

   logic [ufpe_pkg::IDX_W-1:0]     idx_minus;
   logic [ufpe_pkg::BIT_SEL_W-1:0] bit_sel;
   logic                           data_level;
   logic                           ones_odd;

   assign idx_minus  = idx - ufpe_pkg::IDX_W'(1);
   assign bit_sel    = idx_minus[ufpe_pkg::BIT_SEL_W-1:0];
   assign data_level = data_byte[bit_sel];
   assign ones_odd   = ^data_byte[ufpe_pkg::SENT_BITS-1:0];

   always_comb begin
      sym = '0;
      if (idx == ufpe_pkg::IDX_START) begin
         sym.first_level  = 1'b0;
         sym.first_ticks  = cfg.half_bit_ticks;
         sym.second_level = 1'b0;
         sym.second_ticks = cfg.half_bit_ticks;
      end else if (idx == ufpe_pkg::IDX_STOP) begin
         sym.last_symbol  = 1'b1;
         sym.second_level = 1'b1;
         case (cfg.parity_mode)
            ufpe_pkg::PARITY_EVEN: begin
               sym.first_level  = ones_odd;
               sym.first_ticks  = cfg.full_bit_ticks;
               sym.second_ticks = cfg.stop_full_ticks;
            end
            ufpe_pkg::PARITY_ODD: begin
               sym.first_level  = ~ones_odd;
               sym.first_ticks  = cfg.full_bit_ticks;
               sym.second_ticks = cfg.stop_full_ticks;
            end
            default: begin
               sym.first_level  = 1'b1;
               sym.first_ticks  = cfg.stop_half_ticks;
               sym.second_ticks = cfg.stop_half_ticks;
            end
         endcase
      end else begin
         sym.first_level  = data_level;
         sym.first_ticks  = cfg.half_bit_ticks;
         sym.second_level = data_level;
         sym.second_ticks = cfg.half_bit_ticks;
      end
   end

endmodule

@@ src/uart_frame_pulse_encoder_top.sv @@
// Top level of the UART frame pulse encoder: frame register, symbol register, handshakes.
// Usage:
//   req_ channel: one data byte per word, valid/ready handshake.
//   rsp_ channel: one pulse symbol per word (level and ticks for each half, plus a
//   last_symbol flag on the stop symbol), valid/ready handshake.
//   csr_ port: write enable, register index, data; write only while idle.
// A frame is a start symbol, eight data symbols LSB first and one stop symbol,
// ten words in all. With parity on, the stop symbol carries the parity level
// in its first half.
// An accepted byte enters the frame register, then its start symbol the symbol register.
// Throughput: one symbol per cycle while the receiver does not stall; the symbol counter
// of the frame register steps through the frame. The next byte is taken in the cycle
// the stop symbol is loaded, so frames follow with no gap.
// Reset clears both stages and loads the register defaults (no parity, all
// tick counts 1). When the receiver stalls, the symbol register holds its word
// and the frame register holds its position; once a byte sits in the frame
// register req_ready stays low until its stop symbol moves on.
module uart_frame_pulse_encoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ufpe_pkg::BYTE_W-1:0]        req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_first_level,
   output logic [ufpe_pkg::TICK_W-1:0]        rsp_first_ticks,
   output logic                               rsp_second_level,
   output logic [ufpe_pkg::TICK_W-1:0]        rsp_second_ticks,
   output logic                               rsp_last_symbol,
   input  logic                               csr_we,
   input  logic [ufpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ufpe_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ufpe_pkg::cfg_type               cfg;
   ufpe_pkg::sym_type               sym;

   logic                            busy_ff, busy_in;
   logic [ufpe_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [ufpe_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ufpe_pkg::sym_type               rsp_sym_ff, rsp_sym_in;

   logic                            advance;
   logic                            load_sym;
   logic                            at_stop;
   logic                            req_accept;

   ufpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ufpe_sym u_sym (
      .cfg       (cfg),
      .data_byte (byte_ff),
      .idx       (idx_ff),
      .sym       (sym)
   );

   assign advance    = ~rsp_valid_ff | rsp_ready;
   assign load_sym   = busy_ff & advance;
   assign at_stop    = (idx_ff == ufpe_pkg::IDX_STOP);
   assign req_ready  = ~busy_ff | (advance & at_stop);
   assign req_accept = req_valid & req_ready;

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      if (advance) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            rsp_sym_in = sym;
         end
      end
      if (load_sym) begin
         idx_in = idx_ff + ufpe_pkg::IDX_W'(1);
         if (at_stop) begin
            busy_in = 1'b0;
         end
      end
      if (req_accept) begin
         busy_in = 1'b1;
         idx_in  = ufpe_pkg::IDX_START;
         byte_in = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= ufpe_pkg::IDX_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      rsp_sym_ff <= rsp_sym_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_level  = rsp_sym_ff.first_level;
   assign rsp_first_ticks  = rsp_sym_ff.first_ticks;
   assign rsp_second_level = rsp_sym_ff.second_level;
   assign rsp_second_ticks = rsp_sym_ff.second_ticks;
   assign rsp_last_symbol  = rsp_sym_ff.last_symbol;

`ifndef ASSERT_OFF
   a_accept_starts_frame: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (busy_ff && idx_ff == ufpe_pkg::IDX_START))
      else $error("accepted byte did not start a frame at the start symbol");

   a_ready_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (req_ready && busy_ff) |-> (advance && at_stop))
      else $error("byte taken while a frame is still in progress");

   a_stop_flags_last: assert property (@(posedge clock) disable iff (reset)
      (load_sym && at_stop) |=> (rsp_valid && rsp_last_symbol))
      else $error("stop symbol left without last_symbol");

   a_start_is_low: assert property (@(posedge clock) disable iff (reset)
      (load_sym && idx_ff == ufpe_pkg::IDX_START)
         |=> (!rsp_first_level && !rsp_second_level && !rsp_last_symbol))
      else $error("start symbol is not low");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the UART frame pulse encoder: bytes in, ten-symbol frames out.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_COUNT = 5;
   localparam logic [1:0] PARITY_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BYTES = 32;
   localparam logic [ufpe_pkg::TICK_W-1:0] TICKS_MAX = '1;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY} stall_style_type;

   class frame_scoreboard;
      ufpe_pkg::sym_type frame_syms[$];
      logic [1:0] parity_mode;
      logic [ufpe_pkg::TICK_W-1:0] half_bit_ticks;
      logic [ufpe_pkg::TICK_W-1:0] full_bit_ticks;
      logic [ufpe_pkg::TICK_W-1:0] stop_half_ticks;
      logic [ufpe_pkg::TICK_W-1:0] stop_full_ticks;
      int errors;
      int symbols_seen;

      function new();
         parity_mode = ufpe_pkg::PARITY_NONE;
         half_bit_ticks = 15'd1;
         full_bit_ticks = 15'd1;
         stop_half_ticks = 15'd1;
         stop_full_ticks = 15'd1;
         errors = 0;
         symbols_seen = 0;
      endfunction

      function void write_reg(logic [ufpe_pkg::CSR_IDX_W-1:0] idx,
                              logic [ufpe_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            ufpe_pkg::CSR_PARITY_MODE:     parity_mode = data[1:0];
            ufpe_pkg::CSR_HALF_BIT_TICKS:  half_bit_ticks = data[ufpe_pkg::TICK_W-1:0];
            ufpe_pkg::CSR_FULL_BIT_TICKS:  full_bit_ticks = data[ufpe_pkg::TICK_W-1:0];
            ufpe_pkg::CSR_STOP_HALF_TICKS: stop_half_ticks = data[ufpe_pkg::TICK_W-1:0];
            ufpe_pkg::CSR_STOP_FULL_TICKS: stop_full_ticks = data[ufpe_pkg::TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_byte(logic [ufpe_pkg::BYTE_W-1:0] b);
         ufpe_pkg::sym_type s;
         logic ones;
         ones = 1'b0;
         s = '{1'b0, half_bit_ticks, 1'b0, half_bit_ticks, 1'b0};
         frame_syms.push_back(s);
         for (int i = 0; i < ufpe_pkg::SENT_BITS; i++) begin
            ones ^= b[i];
            s = '{b[i], half_bit_ticks, b[i], half_bit_ticks, 1'b0};
            frame_syms.push_back(s);
         end
         if (parity_mode == ufpe_pkg::PARITY_EVEN || parity_mode == ufpe_pkg::PARITY_ODD) begin
            s = '{ones ^ (parity_mode == ufpe_pkg::PARITY_ODD), full_bit_ticks,
                  1'b1, stop_full_ticks, 1'b1};
         end else begin
            s = '{1'b1, stop_half_ticks, 1'b1, stop_half_ticks, 1'b1};
         end
         frame_syms.push_back(s);
      endfunction

      function int pending();
         return frame_syms.size();
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("tb: %s mismatch at symbol %0d: got %0d, want %0d",
                  what, symbols_seen, got, want);
      endtask

      task check_symbol(ufpe_pkg::sym_type got);
         ufpe_pkg::sym_type want;
         if (frame_syms.size() == 0) begin
            report("unexpected symbol", 1, 0);
         end else begin
            want = frame_syms.pop_front();
            if (got.first_level !== want.first_level)
               report("first_level", got.first_level, want.first_level);
            if (got.first_ticks !== want.first_ticks)
               report("first_ticks", got.first_ticks, want.first_ticks);
            if (got.second_level !== want.second_level)
               report("second_level", got.second_level, want.second_level);
            if (got.second_ticks !== want.second_ticks)
               report("second_ticks", got.second_ticks, want.second_ticks);
            if (got.last_symbol !== want.last_symbol)
               report("last_symbol", got.last_symbol, want.last_symbol);
         end
         symbols_seen++;
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [ufpe_pkg::BYTE_W-1:0] req_data_byte;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_first_level;
   logic [ufpe_pkg::TICK_W-1:0] rsp_first_ticks;
   logic rsp_second_level;
   logic [ufpe_pkg::TICK_W-1:0] rsp_second_ticks;
   logic rsp_last_symbol;
   logic csr_we;
   logic [ufpe_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ufpe_pkg::CSR_DATA_W-1:0] csr_wdata;

   frame_scoreboard sb = new();
   bit hold_off = 1'b0;
   int burst_left = 0;

   uart_frame_pulse_encoder_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_first_level  (rsp_first_level),
      .rsp_first_ticks  (rsp_first_ticks),
      .rsp_second_level (rsp_second_level),
      .rsp_second_ticks (rsp_second_ticks),
      .rsp_last_symbol  (rsp_last_symbol),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_byte(req_data_byte);
         if (rsp_valid && rsp_ready)
            sb.check_symbol({rsp_first_level, rsp_first_ticks, rsp_second_level,
                             rsp_second_ticks, rsp_last_symbol});
      end
   end

   initial begin
      stall_style_type style;
      int run_left;
      style = STALL_NONE;
      run_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            if (run_left == 0) begin
               style = stall_style_type'($urandom_range(0, 2));
               run_left = $urandom_range(8, 64);
            end
            run_left--;
            case (style)
               STALL_NONE:  rsp_ready <= 1'b1;
               STALL_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_ready <= ($urandom_range(0, 7) == 0);
               default:     rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   task automatic send_byte(input logic [ufpe_pkg::BYTE_W-1:0] b);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_random(input int n, input bit with_hold);
      for (int i = 0; i < n; i++) begin
         if (with_hold && i == 3)
            hold_off = 1'b1;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
               pause($urandom_range(1, 15));
         end
         burst_left--;
         send_byte(ufpe_pkg::BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic drain();
      int waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [ufpe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ufpe_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [ufpe_pkg::CSR_DATA_W-1:0] parity,
                             input logic [ufpe_pkg::TICK_W-1:0] half,
                             input logic [ufpe_pkg::TICK_W-1:0] full,
                             input logic [ufpe_pkg::TICK_W-1:0] stop_half,
                             input logic [ufpe_pkg::TICK_W-1:0] stop_full);
      csr_write(ufpe_pkg::CSR_PARITY_MODE, parity);
      csr_write(ufpe_pkg::CSR_HALF_BIT_TICKS, half);
      csr_write(ufpe_pkg::CSR_FULL_BIT_TICKS, full);
      csr_write(ufpe_pkg::CSR_STOP_HALF_TICKS, stop_half);
      csr_write(ufpe_pkg::CSR_STOP_FULL_TICKS, stop_full);
      csr_release();
   endtask

   function automatic logic [ufpe_pkg::TICK_W-1:0] pick_ticks();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 15'd1;
         2:       return TICKS_MAX;
         default: return ufpe_pkg::TICK_W'($urandom_range(0, TICKS_MAX));
      endcase
   endfunction

   initial begin
      logic [ufpe_pkg::BYTE_W-1:0] plain_bytes[5] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55};
      logic [ufpe_pkg::BYTE_W-1:0] even_bytes[4] = '{8'h00, 8'hFF, 8'h01, 8'h0F};
      logic [ufpe_pkg::BYTE_W-1:0] odd_bytes[4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};
      logic [ufpe_pkg::BYTE_W-1:0] unused_bytes[3] = '{8'h00, 8'hFF, 8'h5A};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plain_bytes[i]) send_byte(plain_bytes[i]);
      drain();

      set_config(ufpe_pkg::CSR_DATA_W'(ufpe_pkg::PARITY_EVEN), TICKS_MAX, 15'd1, 15'd0,
                 TICKS_MAX);
      foreach (even_bytes[i]) send_byte(even_bytes[i]);
      drain();

      set_config(ufpe_pkg::CSR_DATA_W'(ufpe_pkg::PARITY_ODD), 15'd0, TICKS_MAX, TICKS_MAX,
                 15'd0);
      for (int k = 0; k < 8 - CSR_COUNT; k++)
         csr_write(ufpe_pkg::CSR_IDX_W'(CSR_COUNT + k), '0);
      csr_release();
      foreach (odd_bytes[i]) send_byte(odd_bytes[i]);
      drain();

      // upper bits of a wide parity write drop out, leaving no parity
      csr_write(ufpe_pkg::CSR_PARITY_MODE, 15'h7FFC);
      csr_release();
      send_byte(8'hAA);
      send_byte(8'h00);
      drain();

      set_config(ufpe_pkg::CSR_DATA_W'(PARITY_UNUSED), 15'd1, 15'd1, 15'd0, 15'd1);
      foreach (unused_bytes[i]) send_byte(unused_bytes[i]);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_config(ufpe_pkg::CSR_DATA_W'($urandom_range(0, TICKS_MAX)), pick_ticks(),
                    pick_ticks(), pick_ticks(), pick_ticks());
         if ($urandom_range(0, 2) == 0) begin
            csr_write(ufpe_pkg::CSR_IDX_W'($urandom_range(CSR_COUNT, 7)),
                      ufpe_pkg::CSR_DATA_W'($urandom_range(0, TICKS_MAX)));
            csr_release();
         end
         send_random(PHASE_BYTES, p == 2);
         drain();
      end

      if (sb.pending() != 0)
         sb.report("missing symbols", 0, sb.pending());
      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: errors");
      $finish;
   end
endmodule

@@ files.f @@
src/ufpe_pkg.sv
src/ufpe_csr.sv
src/ufpe_sym.sv
src/uart_frame_pulse_encoder_top.sv
tb/tb.sv
